// ===== sv/elp_pkg.sv =====
// Shared types, codes and helpers for the entity lump parser.
package elp_pkg;

    localparam int ELP_OFFSET_BITS = 32;
    localparam int ResQDepth       = 4;

    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam logic [2:0] EV_OPEN   = 3'd0;
    localparam logic [2:0] EV_KEYCH  = 3'd1;
    localparam logic [2:0] EV_KEYEND = 3'd2;
    localparam logic [2:0] EV_VALCH  = 3'd3;
    localparam logic [2:0] EV_VALEND = 3'd4;
    localparam logic [2:0] EV_CLOSE  = 3'd5;
    localparam logic [2:0] EV_DONE   = 3'd6;
    localparam logic [2:0] EV_ERROR  = 3'd7;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_NO_OPENER   = 3'd1;
    localparam logic [2:0] ERR_OPEN_BLOCK  = 3'd2;
    localparam logic [2:0] ERR_NO_QUOTE    = 3'd3;
    localparam logic [2:0] ERR_OPEN_ESCAPE = 3'd4;
    localparam logic [2:0] ERR_OPEN_STRING = 3'd5;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  char_out;
        logic [2:0]  error_code;
        logic [31:0] error_offset;
        logic        final_result;
    } out_item_t;

    function automatic logic is_ws(logic [7:0] b);
        return ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
    endfunction

endpackage

// ===== sv/elp_stream_if.sv =====
// Valid/ready stream channel carrying one payload item per beat.
interface elp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/entity_lump_parser.sv =====
// Entity lump parser: byte-serial recogniser for brace blocks of quoted key/value pairs.
// Results are registered in the result queue before they are offered on the output.
// Throughput: one byte per cycle; a last byte may yield two results, absorbed by a
// four-entry result queue, so input stalls only while the queue has fewer than two free slots.
// Reset (rst_n low, asynchronous): phase to top level, byte position to zero, queue empty.
// An end-of-text beat returns phase and position to their reset values as well.
module entity_lump_parser
    import elp_pkg::*;
#(
    parameter int OFFSET_BITS = ELP_OFFSET_BITS
)
(
    input  logic         clk,
    input  logic         rst_n,
    elp_stream_if.sink   in_ch,
    elp_stream_if.source out_ch
);

    localparam logic [3:0] PH_TOP     = 4'd0;
    localparam logic [3:0] PH_BLOCK   = 4'd1;
    localparam logic [3:0] PH_KEY     = 4'd2;
    localparam logic [3:0] PH_KEY_ESC = 4'd3;
    localparam logic [3:0] PH_BETWEEN = 4'd4;
    localparam logic [3:0] PH_VAL     = 4'd5;
    localparam logic [3:0] PH_VAL_ESC = 4'd6;
    localparam logic [3:0] PH_DRAIN   = 4'd7;

    localparam int ExtW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;
    localparam int PtrW = $clog2(ResQDepth);
    localparam int CntW = $clog2(ResQDepth + 1);

    logic [3:0]             phase_reg, phase_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_inc;
    logic [ExtW-1:0]        here_ext, len_ext;
    logic [31:0]            here_sat, len_sat;

    out_item_t              q_mem [ResQDepth];
    logic [PtrW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]        cnt_reg;

    logic      accept, pop;
    logic [7:0] b;
    logic      last;
    logic      ev_valid, end_valid;
    out_item_t ev_item, end_item;
    logic [1:0] push_n;

    assign accept = in_ch.valid && in_ch.ready;
    assign pop    = out_ch.valid && out_ch.ready;
    assign b      = in_ch.data.text_byte;
    assign last   = in_ch.data.end_of_text;

    assign in_ch.ready  = (cnt_reg <= CntW'(ResQDepth - 2));
    assign out_ch.valid = (cnt_reg != '0);
    assign out_ch.data  = q_mem[rd_ptr_reg];

    assign pos_inc  = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign here_ext = ExtW'(pos_reg);
    assign len_ext  = ExtW'(pos_inc);
    assign here_sat = (here_ext > ExtW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : here_ext[31:0];
    assign len_sat  = (len_ext > ExtW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : len_ext[31:0];

    // Byte event and phase step
    always_comb
    begin
        phase_next = phase_reg;
        ev_valid   = 1'b0;
        ev_item    = '0;
        unique case (phase_reg)
            PH_TOP:
            begin
                if (b == CH_LBRACE)
                begin
                    ev_valid           = 1'b1;
                    ev_item.event_res  = EV_OPEN;
                    phase_next         = PH_BLOCK;
                end
                else if (!is_ws(b))
                begin
                    ev_valid             = 1'b1;
                    ev_item.event_res    = EV_ERROR;
                    ev_item.error_code   = ERR_NO_OPENER;
                    ev_item.error_offset = here_sat;
                    ev_item.final_result = 1'b1;
                    phase_next           = PH_DRAIN;
                end
            end
            PH_BLOCK:
            begin
                if (b == CH_RBRACE)
                begin
                    ev_valid          = 1'b1;
                    ev_item.event_res = EV_CLOSE;
                    phase_next        = PH_TOP;
                end
                else if (b == CH_QUOTE)
                begin
                    phase_next = PH_KEY;
                end
                else if (!is_ws(b))
                begin
                    ev_valid             = 1'b1;
                    ev_item.event_res    = EV_ERROR;
                    ev_item.error_code   = ERR_NO_QUOTE;
                    ev_item.error_offset = here_sat;
                    ev_item.final_result = 1'b1;
                    phase_next           = PH_DRAIN;
                end
            end
            PH_KEY:
            begin
                if (b == CH_QUOTE)
                begin
                    ev_valid          = 1'b1;
                    ev_item.event_res = EV_KEYEND;
                    phase_next        = PH_BETWEEN;
                end
                else if (b == CH_BACKSLASH)
                begin
                    phase_next = PH_KEY_ESC;
                end
                else
                begin
                    ev_valid          = 1'b1;
                    ev_item.event_res = EV_KEYCH;
                    ev_item.char_out  = b;
                end
            end
            PH_KEY_ESC:
            begin
                ev_valid          = 1'b1;
                ev_item.event_res = EV_KEYCH;
                ev_item.char_out  = b;
                phase_next        = PH_KEY;
            end
            PH_BETWEEN:
            begin
                if (b == CH_QUOTE)
                begin
                    phase_next = PH_VAL;
                end
                else if (!is_ws(b))
                begin
                    ev_valid             = 1'b1;
                    ev_item.event_res    = EV_ERROR;
                    ev_item.error_code   = ERR_NO_QUOTE;
                    ev_item.error_offset = here_sat;
                    ev_item.final_result = 1'b1;
                    phase_next           = PH_DRAIN;
                end
            end
            PH_VAL:
            begin
                if (b == CH_QUOTE)
                begin
                    ev_valid          = 1'b1;
                    ev_item.event_res = EV_VALEND;
                    phase_next        = PH_BLOCK;
                end
                else if (b == CH_BACKSLASH)
                begin
                    phase_next = PH_VAL_ESC;
                end
                else
                begin
                    ev_valid          = 1'b1;
                    ev_item.event_res = EV_VALCH;
                    ev_item.char_out  = b;
                end
            end
            PH_VAL_ESC:
            begin
                ev_valid          = 1'b1;
                ev_item.event_res = EV_VALCH;
                ev_item.char_out  = b;
                phase_next        = PH_VAL;
            end
            default:
            begin
                phase_next = PH_DRAIN;
            end
        endcase
    end

    // End-of-text summary, judged on the phase after this byte
    always_comb
    begin
        end_valid             = 1'b0;
        end_item              = '0;
        end_item.final_result = 1'b1;
        end_item.event_res    = EV_ERROR;
        end_item.error_offset = len_sat;
        unique case (phase_next) inside
            PH_TOP:
            begin
                end_valid             = 1'b1;
                end_item.event_res    = EV_DONE;
                end_item.error_offset = '0;
            end
            PH_BLOCK:
            begin
                end_valid           = 1'b1;
                end_item.error_code = ERR_OPEN_BLOCK;
            end
            PH_BETWEEN:
            begin
                end_valid           = 1'b1;
                end_item.error_code = ERR_NO_QUOTE;
            end
            PH_KEY_ESC, PH_VAL_ESC:
            begin
                end_valid           = 1'b1;
                end_item.error_code = ERR_OPEN_ESCAPE;
            end
            PH_KEY, PH_VAL:
            begin
                end_valid           = 1'b1;
                end_item.error_code = ERR_OPEN_STRING;
            end
            default:
            begin
                end_valid = 1'b0;
            end
        endcase
        end_valid = end_valid && last;
    end

    assign push_n = accept ? (2'(ev_valid) + 2'(end_valid)) : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TOP;
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                // rearm for the next text after the last byte
                phase_reg <= last ? PH_TOP : phase_next;
                pos_reg   <= last ? '0 : pos_inc;
            end
            wr_ptr_reg <= wr_ptr_reg + PtrW'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + CntW'(push_n) - CntW'(pop);
        end
    end

    // Result queue storage; byte event goes first, the summary behind it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (ev_valid)
            begin
                q_mem[wr_ptr_reg] <= ev_item;
                if (end_valid)
                begin
                    q_mem[wr_ptr_reg + 1'b1] <= end_item;
                end
            end
            else if (end_valid)
            begin
                q_mem[wr_ptr_reg] <= end_item;
            end
        end
    end

endmodule

// ===== sv/elp_checker.sv =====
// Port-level assertions for the entity lump parser, bound to the top level.
module elp_checker
    import elp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_final_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.final_result |->
            (out_data.event_res == EV_DONE || out_data.event_res == EV_ERROR))
        else $error("final beat is neither done nor error");

    a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.event_res == EV_ERROR) == (out_data.error_code != ERR_NONE)))
        else $error("error code does not match event");

    a_char_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res != EV_KEYCH && out_data.event_res != EV_VALCH |->
            out_data.char_out == 8'h00)
        else $error("character on a non-character event");

    a_offset_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.event_res != EV_ERROR |->
            out_data.error_offset == 32'h0 && out_data.final_result == (out_data.event_res == EV_DONE))
        else $error("offset or final flag on a non-error event");

endmodule

bind entity_lump_parser elp_checker u_elp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

// ===== bench/elp_event_checker.sv =====
// Event checker for the entity lump parser: predicts events per text beat and compares.
`timescale 1ns / 1ps

module elp_event_checker
    import elp_pkg::*;
#(
    parameter int OFFSET_BITS = ELP_OFFSET_BITS
)
(
    input  logic  clk,
    input  logic  rst_n,
    elp_stream_if in_ch,
    elp_stream_if out_ch,
    output int    mismatches,
    output int    events_pending
);

    typedef enum logic [3:0] {
        PH_TOP,
        PH_BLOCK,
        PH_KEY,
        PH_KEY_ESC,
        PH_BETWEEN,
        PH_VAL,
        PH_VAL_ESC,
        PH_DRAIN
    } phase_t;

    localparam logic [63:0] POS_MAX = (64'd1 << OFFSET_BITS) - 64'd1;

    phase_t      phase;
    logic [63:0] position;
    out_item_t   expected_events[$];

    function automatic logic [31:0] clip_offset(logic [63:0] p);
        return (p > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endfunction

    function automatic void add_event(logic [2:0] ev, logic [7:0] ch, logic [2:0] code,
                                      logic [31:0] off, logic fin);
        out_item_t e;
        e.event_res    = ev;
        e.char_out     = ch;
        e.error_code   = code;
        e.error_offset = off;
        e.final_result = fin;
        expected_events.insert(expected_events.size(), e);
    endfunction

    task automatic parse_byte(input in_item_t item);
        logic [7:0]  b;
        logic        blank;
        logic [31:0] here;
        b     = item.text_byte;
        blank = ((b >= 8'h09) && (b <= 8'h0D)) || (b == 8'h20);
        here  = clip_offset(position);
        case (phase)
            PH_TOP:
                if (b == CH_LBRACE) begin
                    add_event(EV_OPEN, 8'h00, ERR_NONE, 32'd0, 1'b0);
                    phase = PH_BLOCK;
                end else if (!blank) begin
                    add_event(EV_ERROR, 8'h00, ERR_NO_OPENER, here, 1'b1);
                    phase = PH_DRAIN;
                end
            PH_BLOCK:
                if (b == CH_RBRACE) begin
                    add_event(EV_CLOSE, 8'h00, ERR_NONE, 32'd0, 1'b0);
                    phase = PH_TOP;
                end else if (b == CH_QUOTE) begin
                    phase = PH_KEY;
                end else if (!blank) begin
                    add_event(EV_ERROR, 8'h00, ERR_NO_QUOTE, here, 1'b1);
                    phase = PH_DRAIN;
                end
            PH_KEY:
                if (b == CH_QUOTE) begin
                    add_event(EV_KEYEND, 8'h00, ERR_NONE, 32'd0, 1'b0);
                    phase = PH_BETWEEN;
                end else if (b == CH_BACKSLASH) begin
                    phase = PH_KEY_ESC;
                end else begin
                    add_event(EV_KEYCH, b, ERR_NONE, 32'd0, 1'b0);
                end
            PH_KEY_ESC:
            begin
                add_event(EV_KEYCH, b, ERR_NONE, 32'd0, 1'b0);
                phase = PH_KEY;
            end
            PH_BETWEEN:
                if (b == CH_QUOTE) begin
                    phase = PH_VAL;
                end else if (!blank) begin
                    add_event(EV_ERROR, 8'h00, ERR_NO_QUOTE, here, 1'b1);
                    phase = PH_DRAIN;
                end
            PH_VAL:
                if (b == CH_QUOTE) begin
                    add_event(EV_VALEND, 8'h00, ERR_NONE, 32'd0, 1'b0);
                    phase = PH_BLOCK;
                end else if (b == CH_BACKSLASH) begin
                    phase = PH_VAL_ESC;
                end else begin
                    add_event(EV_VALCH, b, ERR_NONE, 32'd0, 1'b0);
                end
            PH_VAL_ESC:
            begin
                add_event(EV_VALCH, b, ERR_NONE, 32'd0, 1'b0);
                phase = PH_VAL;
            end
            default:
                phase = PH_DRAIN;
        endcase

        if (position < POS_MAX)
            position++;

        // a closing error event reports the text length, i.e. the position after this byte
        if (item.end_of_text) begin
            case (phase) inside
                PH_TOP:
                    add_event(EV_DONE, 8'h00, ERR_NONE, 32'd0, 1'b1);
                PH_BLOCK:
                    add_event(EV_ERROR, 8'h00, ERR_OPEN_BLOCK, clip_offset(position), 1'b1);
                PH_BETWEEN:
                    add_event(EV_ERROR, 8'h00, ERR_NO_QUOTE, clip_offset(position), 1'b1);
                PH_KEY_ESC, PH_VAL_ESC:
                    add_event(EV_ERROR, 8'h00, ERR_OPEN_ESCAPE, clip_offset(position), 1'b1);
                PH_KEY, PH_VAL:
                    add_event(EV_ERROR, 8'h00, ERR_OPEN_STRING, clip_offset(position), 1'b1);
                default:
                    ;
            endcase
            phase    = PH_TOP;
            position = '0;
        end
    endtask

    task automatic check_event(input out_item_t got);
        out_item_t want;
        if (expected_events.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected event: expected none, got ev=%0d ch=%02h code=%0d off=%0d fin=%0b",
                     $time, got.event_res, got.char_out, got.error_code,
                     got.error_offset, got.final_result);
        end else begin
            want = expected_events.pop_front();
            if (got.event_res !== want.event_res || got.char_out !== want.char_out ||
                got.error_code !== want.error_code ||
                got.error_offset !== want.error_offset ||
                got.final_result !== want.final_result) begin
                mismatches++;
                $display("%0t: event mismatch: expected ev=%0d ch=%02h code=%0d off=%0d fin=%0b",
                         $time, want.event_res, want.char_out, want.error_code,
                         want.error_offset, want.final_result);
                $display("%0t:                 actual   ev=%0d ch=%02h code=%0d off=%0d fin=%0b",
                         $time, got.event_res, got.char_out, got.error_code,
                         got.error_offset, got.final_result);
            end
        end
    endtask

    initial
    begin
        mismatches = 0;
        events_pending = 0;
        phase = PH_TOP;
        position = '0;
    end

    always @(posedge clk)
    begin
        if (!rst_n) begin
            phase    = PH_TOP;
            position = '0;
            expected_events.delete();
        end else begin
            // take the input beat first; its events can only leave on a later edge
            if (in_ch.valid && in_ch.ready)
                parse_byte(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                check_event(out_ch.data);
        end
        events_pending <= expected_events.size();
    end

endmodule

// ===== bench/entity_lump_parser_tb.sv =====
// Testbench top for the entity lump parser: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps

module entity_lump_parser_tb;
    import elp_pkg::*;

    localparam int OFFSET_BITS  = 16;
    localparam int TARGET_BYTES = 1450;
    localparam int LONG_HOLD    = 400;

    typedef logic [7:0] byte_q_t[$];

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   events_pending;
    int   burst_left = 1;
    int   hold_req = 0;
    int   hold_served = 0;

    elp_stream_if #(.T(in_item_t))  in_ch();
    elp_stream_if #(.T(out_item_t)) out_ch();

    entity_lump_parser #(
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    elp_event_checker #(
        .OFFSET_BITS(OFFSET_BITS)
    ) event_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .mismatches     (mismatches),
        .events_pending (events_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] ws_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'h09 + 8'(r);
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_QUOTE || b == CH_BACKSLASH);
        return b;
    endfunction

    function automatic void add_ws(ref byte_q_t t, input int max_n);
        repeat ($urandom_range(0, max_n))
            t.insert(t.size(), ws_byte());
    endfunction

    function automatic void add_string(ref byte_q_t t, input int max_n);
        t.insert(t.size(), CH_QUOTE);
        repeat ($urandom_range(0, max_n)) begin
            if ($urandom_range(0, 5) == 0) begin
                t.insert(t.size(), CH_BACKSLASH);
                t.insert(t.size(), 8'($urandom_range(0, 255)));
            end else begin
                t.insert(t.size(), plain_byte());
            end
        end
        t.insert(t.size(), CH_QUOTE);
    endfunction

    // Mostly well-formed entity texts, some cut short or corrupted, a few pure noise.
    function automatic byte_q_t make_text();
        byte_q_t t;
        t = {};
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5))
                t.insert(t.size(), 8'($urandom_range(0, 255)));
            return t;
        end
        add_ws(t, 2);
        repeat ($urandom_range(0, 3)) begin
            t.insert(t.size(), CH_LBRACE);
            add_ws(t, 2);
            repeat ($urandom_range(0, 3)) begin
                add_string(t, 5);
                add_ws(t, 2);
                add_string(t, 6);
                add_ws(t, 2);
            end
            t.insert(t.size(), CH_RBRACE);
            add_ws(t, 2);
        end
        if (t.size() == 0)
            t.insert(t.size(), ws_byte());
        case ($urandom_range(0, 7))
            0: t = t[0:$urandom_range(0, t.size() - 1)];
            1: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
            2: t.insert($urandom_range(0, t.size()), 8'($urandom_range(0, 255)));
            default: ;
        endcase
        return t;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        in_ch.data  <= '{text_byte: b, end_of_text: eot};
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_text(input byte_q_t t);
        foreach (t[i])
            send_byte(t[i], i == t.size() - 1);
    endtask

    task automatic wait_for_events();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (events_pending != 0)
            @(posedge clk);
    endtask

    // Receiver: random ready patterns, plus a long hold-off when requested.
    initial
    begin
        int mode;
        int run;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            mode = $urandom_range(0, 3);
            run  = $urandom_range(4, 60);
            repeat (run) begin
                if (hold_served != hold_req) begin
                    out_ch.ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                    hold_served = hold_req;
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= 1'($urandom_range(0, 1));
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ~out_ch.ready;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        byte_q_t t;
        int      counted;
        bit      second_hold;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        counted     = 0;
        second_hold = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full block: NUL key char, escaped quote, tab between, 0xFF value, close, done
        send_text('{CH_LBRACE, CH_QUOTE, 8'h00, CH_BACKSLASH, CH_QUOTE, CH_QUOTE, 8'h09,
                    CH_QUOTE, 8'hFF, CH_QUOTE, CH_RBRACE});
        // stray byte at top level, then a dropped last byte
        send_text('{8'h78, 8'h79});
        // non-quote inside a block on the last byte
        send_text('{CH_LBRACE, 8'h71});
        // text ends between key and value
        send_text('{CH_LBRACE, CH_QUOTE, 8'h61, CH_QUOTE});
        // text ends after a backslash
        send_text('{CH_LBRACE, CH_QUOTE, CH_BACKSLASH});
        // text ends inside a string
        send_text('{CH_LBRACE, CH_QUOTE, 8'h0D});
        // text ends inside a block
        send_text('{CH_LBRACE});
        wait_for_events();

        hold_req++;
        while (counted < TARGET_BYTES) begin
            t = make_text();
            send_text(t);
            counted += t.size();
            if (!second_hold && counted > TARGET_BYTES / 2) begin
                second_hold = 1;
                hold_req++;
            end
            if ($urandom_range(0, 11) == 0)
                wait_for_events();
        end

        wait_for_events();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/elp_pkg.sv
sv/elp_stream_if.sv
sv/entity_lump_parser.sv
sv/elp_checker.sv
bench/elp_event_checker.sv
bench/entity_lump_parser_tb.sv
